// ===== sv/iphfk_pkg.sv =====
// shared types and constants for the ip header flow key parser
package iphfk_pkg;

	// default largest packet length in bytes
	localparam int MAX_PACKET_BYTES_DEF = 65535;

	// fixed byte offsets in the ipv4 header
	localparam int V4_OFF_IHL   = 0;
	localparam int V4_OFF_FLAGS = 6;
	localparam int V4_OFF_PROTO = 9;
	localparam int V4_SRC_LAST  = 15;
	localparam int V4_DST_LAST  = 19;

	// fixed byte offsets in the ipv6 header
	localparam int V6_OFF_NH       = 6;
	localparam int V6_SRC_HI_LAST  = 15;
	localparam int V6_SRC_LO_LAST  = 23;
	localparam int V6_DST_HI_LAST  = 31;
	localparam int V6_DST_LO_LAST  = 39;
	localparam int V6_FIXED_BYTES  = 40;

	// extension header granule and transport header lengths
	localparam int EXT_UNIT_BYTES  = 8;
	localparam int TCP_HDR_BYTES   = 20;
	localparam int SMALL_HDR_BYTES = 8;

	// next header and protocol numbers
	localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
	localparam logic [7:0] NH_ROUTING    = 8'd43;
	localparam logic [7:0] NH_FRAGMENT   = 8'd44;
	localparam logic [7:0] NH_DEST_OPTS  = 8'd60;
	localparam logic [7:0] PROTO_ICMP    = 8'd1;
	localparam logic [7:0] PROTO_TCP     = 8'd6;
	localparam logic [7:0] PROTO_UDP     = 8'd17;
	localparam logic [7:0] PROTO_ICMPV6  = 8'd58;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_V4_BAD     = 2'd1,
		ST_V6_TRUNC   = 2'd2,
		ST_V6_UNKNOWN = 2'd3
	} status_t;

	// ipv6 header chain walk
	typedef enum logic [3:0] {
		PH_FIXED   = 4'b0001,
		PH_EXT     = 4'b0010,
		PH_XPORT   = 4'b0100,
		PH_UNKNOWN = 4'b1000
	} phase_t;

	// one input byte request
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic       v6;
	} byte_req_t;

	// one flow key result
	typedef struct packed {
		status_t     status;
		logic        is_ipv4;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [7:0]  protocol;
		logic [15:0] source_port;
		logic [15:0] dest_port;
	} flow_key_t;

endpackage

// ===== sv/iphfk_in_stage.sv =====
// input register stage holding one byte request
module iphfk_in_stage import iphfk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  byte_req_t in_req,
	input  logic      advance,
	output logic      valid_s1,
	output byte_req_t req_s1
);

	// stage takes a new request when empty or when its content moves on
	assign in_ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_req;
		end
	end

endmodule

// ===== sv/iphfk_parse_core.sv =====
// per packet parse state and flow key logic, one byte per cycle while advance is high
module iphfk_parse_core import iphfk_pkg::*; #(
	parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  byte_req_t req_s1,
	output flow_key_t key
);

	localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int END_W = $clog2(MAX_PACKET_BYTES + 256 * EXT_UNIT_BYTES + 1);

	// packet state
	logic [POS_W-1:0] pos_q;
	logic             v6_q;
	logic [3:0]       hlw_q;
	logic             mf_q;
	logic [7:0]       nh_q;
	logic [POS_W-1:0] hstart_q;
	logic [END_W-1:0] hend_q;
	phase_t           phase_q;
	logic [63:0]      src_hi_q, src_lo_q, dst_hi_q, dst_lo_q;
	logic [7:0]       proto_q;
	logic [31:0]      port_q;

	// next state
	logic [POS_W-1:0] n_pos;
	logic             n_v6;
	logic [3:0]       n_hlw;
	logic             n_mf;
	logic [7:0]       n_nh;
	logic [POS_W-1:0] n_hstart;
	logic [END_W-1:0] n_hend;
	phase_t           n_phase;
	logic [63:0]      n_src_hi, n_src_lo, n_dst_hi, n_dst_lo;
	logic [7:0]       n_proto;
	logic [31:0]      n_port;

	// kind of header a next header number opens
	function automatic phase_t nh_kind(input logic [7:0] nh);
		phase_t ph;
		ph = PH_UNKNOWN;
		if (nh == NH_HOP_BY_HOP || nh == NH_ROUTING || nh == NH_FRAGMENT ||
				nh == NH_DEST_OPTS) begin
			ph = PH_EXT;
		end else if (nh == PROTO_ICMP || nh == PROTO_TCP || nh == PROTO_UDP ||
				nh == PROTO_ICMPV6) begin
			ph = PH_XPORT;
		end
		return ph;
	endfunction

	// byte update, starting from cleared state at a packet start
	always_comb begin
		logic             start;
		logic [POS_W-1:0] p;
		logic [POS_W-1:0] hl;
		logic [POS_W-1:0] off;
		logic [POS_W-1:0] enter_at;
		logic             enter;
		logic [7:0]       d;

		d     = req_s1.data;
		start = req_s1.first || (pos_q == '0);
		p     = start ? '0 : pos_q;

		n_pos    = p;
		n_v6     = start ? req_s1.v6 : v6_q;
		n_hlw    = start ? 4'd0 : hlw_q;
		n_mf     = start ? 1'b0 : mf_q;
		n_nh     = start ? 8'd0 : nh_q;
		n_hstart = start ? '0 : hstart_q;
		n_hend   = start ? '0 : hend_q;
		n_phase  = start ? PH_FIXED : phase_q;
		n_src_hi = start ? 64'd0 : src_hi_q;
		n_src_lo = start ? 64'd0 : src_lo_q;
		n_dst_hi = start ? 64'd0 : dst_hi_q;
		n_dst_lo = start ? 64'd0 : dst_lo_q;
		n_proto  = start ? 8'd0 : proto_q;
		n_port   = start ? 32'd0 : port_q;

		hl       = '0;
		off      = '0;
		enter    = 1'b0;
		enter_at = '0;

		if (p < POS_W'(MAX_PACKET_BYTES)) begin
			n_pos = p + POS_W'(1);
			if (!n_v6) begin
				// ipv4 fixed fields
				if (p == POS_W'(V4_OFF_IHL))   n_hlw   = d[3:0];
				if (p == POS_W'(V4_OFF_FLAGS)) n_mf    = d[5];
				if (p == POS_W'(V4_OFF_PROTO)) n_proto = d;
				for (int k = 0; k < 4; k++) begin
					if (p == POS_W'(V4_SRC_LAST - k))
						n_src_lo[k*8 +: 8] = n_src_lo[k*8 +: 8] | d;
					if (p == POS_W'(V4_DST_LAST - k))
						n_dst_lo[k*8 +: 8] = n_dst_lo[k*8 +: 8] | d;
				end
				// first four bytes after the ihl boundary
				hl  = POS_W'({n_hlw, 2'b00});
				off = p - hl;
				if (p >= hl && p < hl + POS_W'(4)) begin
					for (int k = 0; k < 4; k++) begin
						if (off[1:0] == 2'(3 - k))
							n_port[k*8 +: 8] = n_port[k*8 +: 8] | d;
					end
				end
			end else if (p < POS_W'(V6_FIXED_BYTES)) begin
				// ipv6 fixed header
				if (p == POS_W'(V6_OFF_NH)) n_nh = d;
				for (int k = 0; k < 8; k++) begin
					if (p == POS_W'(V6_SRC_HI_LAST - k))
						n_src_hi[k*8 +: 8] = n_src_hi[k*8 +: 8] | d;
					if (p == POS_W'(V6_SRC_LO_LAST - k))
						n_src_lo[k*8 +: 8] = n_src_lo[k*8 +: 8] | d;
					if (p == POS_W'(V6_DST_HI_LAST - k))
						n_dst_hi[k*8 +: 8] = n_dst_hi[k*8 +: 8] | d;
					if (p == POS_W'(V6_DST_LO_LAST - k))
						n_dst_lo[k*8 +: 8] = n_dst_lo[k*8 +: 8] | d;
				end
				if (p == POS_W'(V6_DST_LO_LAST)) begin
					enter    = 1'b1;
					enter_at = POS_W'(V6_FIXED_BYTES);
				end
			end else begin
				// ipv6 header chain
				off = p - n_hstart;
				unique case (n_phase)
					PH_EXT: begin
						if (off == '0) n_nh = d;
						if (off == POS_W'(1))
							n_hend = END_W'(n_hstart) +
								((END_W'(d) + END_W'(1)) << 3);
						if (off != '0 && (END_W'(p) + END_W'(1)) == n_hend) begin
							enter    = 1'b1;
							enter_at = n_hend[POS_W-1:0];
						end
					end
					PH_XPORT: begin
						if (off < POS_W'(4)) begin
							for (int k = 0; k < 4; k++) begin
								if (off[1:0] == 2'(3 - k))
									n_port[k*8 +: 8] = n_port[k*8 +: 8] | d;
							end
						end
					end
					default: begin
					end
				endcase
			end
			// open the next header in the chain
			if (enter) begin
				n_hstart = enter_at;
				n_phase  = nh_kind(n_nh);
				if (n_phase == PH_EXT)
					n_hend = END_W'(enter_at) + END_W'(EXT_UNIT_BYTES);
				if (n_phase == PH_XPORT)
					n_proto = n_nh;
			end
		end
	end

	// flow key for a packet ending with this byte
	always_comb begin
		logic [END_W-1:0] need;
		logic [15:0]      sp, dp;
		status_t          st;

		st   = ST_OK;
		need = END_W'(n_hstart) + ((n_proto == PROTO_TCP) ?
			END_W'(TCP_HDR_BYTES) : END_W'(SMALL_HDR_BYTES));
		if (!n_v6) begin
			if (n_mf || n_pos < POS_W'({n_hlw, 2'b00})) st = ST_V4_BAD;
		end else if (n_phase == PH_FIXED || n_phase == PH_EXT) begin
			st = ST_V6_TRUNC;
		end else if (n_phase == PH_UNKNOWN) begin
			st = ST_V6_UNKNOWN;
		end else if (END_W'(n_pos) < need) begin
			st = ST_V6_TRUNC;
		end

		sp = 16'd0;
		dp = 16'd0;
		if (n_proto == PROTO_TCP || n_proto == PROTO_UDP) begin
			sp = n_port[31:16];
			dp = n_port[15:0];
		end else if (n_proto == PROTO_ICMP || (n_v6 && n_proto == PROTO_ICMPV6)) begin
			sp = {8'd0, n_port[31:24]};
			dp = {8'd0, n_port[23:16]};
		end

		key.status      = st;
		key.is_ipv4     = !n_v6;
		key.src_hi      = n_v6 ? n_src_hi : 64'd0;
		key.src_lo      = n_v6 ? n_src_lo : {32'd0, n_src_lo[31:0]};
		key.dst_hi      = n_v6 ? n_dst_hi : 64'd0;
		key.dst_lo      = n_v6 ? n_dst_lo : {32'd0, n_dst_lo[31:0]};
		key.protocol    = (st == ST_OK) ? n_proto : 8'd0;
		key.source_port = (st == ST_OK) ? sp : 16'd0;
		key.dest_port   = (st == ST_OK) ? dp : 16'd0;
	end

	// state registers, position back to zero after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			v6_q     <= 1'b0;
			hlw_q    <= 4'd0;
			mf_q     <= 1'b0;
			nh_q     <= 8'd0;
			hstart_q <= '0;
			hend_q   <= '0;
			phase_q  <= PH_FIXED;
			src_hi_q <= 64'd0;
			src_lo_q <= 64'd0;
			dst_hi_q <= 64'd0;
			dst_lo_q <= 64'd0;
			proto_q  <= 8'd0;
			port_q   <= 32'd0;
		end else if (advance) begin
			pos_q    <= req_s1.last ? '0 : n_pos;
			v6_q     <= n_v6;
			hlw_q    <= n_hlw;
			mf_q     <= n_mf;
			nh_q     <= n_nh;
			hstart_q <= n_hstart;
			hend_q   <= n_hend;
			phase_q  <= n_phase;
			src_hi_q <= n_src_hi;
			src_lo_q <= n_src_lo;
			dst_hi_q <= n_dst_hi;
			dst_lo_q <= n_dst_lo;
			proto_q  <= n_proto;
			port_q   <= n_port;
		end
	end

endmodule

// ===== sv/iphfk_out_stage.sv =====
// result register toward the downstream receiver
module iphfk_out_stage import iphfk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  flow_key_t key,
	output logic      out_valid,
	input  logic      out_ready,
	output flow_key_t key_s2,
	output logic      busy
);

	// a held result blocks the next one until taken
	assign busy = out_valid && !out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			key_s2 <= key;
		end
	end

endmodule

// ===== sv/ip_header_flow_key_parser_unit.sv =====
// top level of the ip header flow key parser
//
// Bytes of a packet, starting at the network header, enter on the s_axis
// channel, one byte per request. tuser[0] marks the first byte, tuser[1]
// selects ipv6 parsing (sampled at the start of a packet) and tlast marks
// the final byte. A byte that arrives when no packet is open also starts one.
// For every final byte one flow key request leaves on m_axis: status,
// addresses, protocol and ports in tdata, the ipv4 flag in tuser.
// Throughput is one byte per cycle unless a last byte waits for the result
// register; the per-byte state update is a single pass of logic between the
// input register and the packet state. The flow key passes the input
// register, then the result register, where it becomes valid on m_axis.
// When the receiver stalls, the result register holds its key; bytes keep
// flowing until a further last byte reaches the input register, which then
// waits until the held key is taken.
// Reset clears the packet state and both valid flags; no packet is open.
module ip_header_flow_key_parser_unit import iphfk_pkg::*; #(
	parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // data_byte
	input  logic         s_axis_tlast,  // last_byte
	input  logic [1:0]   s_axis_tuser,  // first_byte, ipv6_mode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, protocol,
	// source_port, dest_port, zero fill
	output logic [303:0] m_axis_tdata,
	output logic [0:0]   m_axis_tuser   // is_ipv4
);

	byte_req_t in_req;
	byte_req_t req_s1;
	logic      valid_s1;
	logic      advance;
	logic      busy;
	flow_key_t key;
	flow_key_t key_s2;

	// input request fields
	assign in_req.data  = s_axis_tdata;
	assign in_req.first = s_axis_tuser[0];
	assign in_req.last  = s_axis_tlast;
	assign in_req.v6    = s_axis_tuser[1];

	// a last byte moves on only when the result register can take its key
	assign advance = valid_s1 && !(req_s1.last && busy);

	iphfk_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_req   (in_req),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	iphfk_parse_core #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_parse_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.req_s1 (req_s1),
		.key    (key)
	);

	iphfk_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && req_s1.last),
		.key       (key),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.key_s2    (key_s2),
		.busy      (busy)
	);

	// result packing, first field in the lowest bits
	assign m_axis_tdata = {6'd0, key_s2.dest_port, key_s2.source_port, key_s2.protocol,
		key_s2.dst_lo, key_s2.dst_hi, key_s2.src_lo, key_s2.src_hi, key_s2.status};
	assign m_axis_tuser = key_s2.is_ipv4;

endmodule

// ===== tb/flow_key_checker.sv =====
// flow key checker: predicts parser results from accepted bytes and compares them
module flow_key_checker import iphfk_pkg::*; #(
	parameter int MAX_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tlast,   // last_byte
	input  logic [1:0]   s_tuser,   // first_byte, ipv6_mode
	input  logic         m_tvalid,
	input  logic         m_tready,
	// status, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, protocol,
	// source_port, dest_port, zero fill
	input  logic [303:0] m_tdata,
	input  logic [0:0]   m_tuser,   // is_ipv4
	output int           fail_count,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// predicted packet state
	int unsigned byte_pos;
	logic        mode6;
	logic [3:0]  ihl_words;
	logic        frag_more;
	logic [7:0]  next_hdr;
	int unsigned hdr_start;
	int unsigned hdr_end;
	phase_t      walk;
	logic [63:0] src_addr [2];
	logic [63:0] dst_addr [2];
	logic [7:0]  proto_found;
	logic [31:0] xport_word;

	// flow keys predicted but not yet seen on the output
	flow_key_t   flow_keys_due [$];
	int          mismatches;
	int          keys_seen;

	task automatic clear_flow();
		byte_pos    = 0;
		mode6       = 1'b0;
		ihl_words   = '0;
		frag_more   = 1'b0;
		next_hdr    = '0;
		hdr_start   = 0;
		hdr_end     = 0;
		walk        = PH_FIXED;
		src_addr    = '{64'd0, 64'd0};
		dst_addr    = '{64'd0, 64'd0};
		proto_found = '0;
		xport_word  = '0;
	endtask

	// classify the header that begins at start
	task automatic open_header(input int unsigned start);
		hdr_start = start;
		case (next_hdr)
			NH_HOP_BY_HOP, NH_ROUTING, NH_FRAGMENT, NH_DEST_OPTS: begin
				walk    = PH_EXT;
				hdr_end = start + EXT_UNIT_BYTES;
			end
			PROTO_ICMP, PROTO_TCP, PROTO_UDP, PROTO_ICMPV6: begin
				walk        = PH_XPORT;
				proto_found = next_hdr;
			end
			default: walk = PH_UNKNOWN;
		endcase
	endtask

	task automatic take_v4(input int unsigned p, input logic [7:0] d);
		int unsigned hl;
		if (p == V4_OFF_IHL) ihl_words = d[3:0];
		if (p == V4_OFF_FLAGS) frag_more = d[5];
		if (p == V4_OFF_PROTO) proto_found = d;
		if (p >= 12 && p <= V4_SRC_LAST)
			src_addr[1] |= 64'(d) << ((V4_SRC_LAST - p) * 8);
		if (p >= 16 && p <= V4_DST_LAST)
			dst_addr[1] |= 64'(d) << ((V4_DST_LAST - p) * 8);
		// transport bytes start at ihl*4, even inside the header
		hl = 32'(ihl_words) * 4;
		if (p >= hl && p < hl + 4)
			xport_word |= 32'(d) << ((3 - (p - hl)) * 8);
	endtask

	task automatic take_v6(input int unsigned p, input logic [7:0] d);
		int unsigned off;
		if (p < V6_FIXED_BYTES) begin
			if (p == V6_OFF_NH) next_hdr = d;
			if (p >= 8 && p <= V6_SRC_HI_LAST)
				src_addr[0] |= 64'(d) << ((V6_SRC_HI_LAST - p) * 8);
			if (p >= 16 && p <= V6_SRC_LO_LAST)
				src_addr[1] |= 64'(d) << ((V6_SRC_LO_LAST - p) * 8);
			if (p >= 24 && p <= V6_DST_HI_LAST)
				dst_addr[0] |= 64'(d) << ((V6_DST_HI_LAST - p) * 8);
			if (p >= 32 && p <= V6_DST_LO_LAST)
				dst_addr[1] |= 64'(d) << ((V6_DST_LO_LAST - p) * 8);
			if (p == V6_DST_LO_LAST) open_header(V6_FIXED_BYTES);
		end else begin
			off = p - hdr_start;
			// extension header: next header at 0, length at 1
			if (walk == PH_EXT) begin
				if (off == 0) next_hdr = d;
				if (off == 1) hdr_end = hdr_start + (32'(d) + 1) * EXT_UNIT_BYTES;
				if (off >= 1 && p + 1 == hdr_end) open_header(hdr_end);
			end else if (walk == PH_XPORT && off < 4) begin
				xport_word |= 32'(d) << ((3 - off) * 8);
			end
		end
	endtask

	// advance the prediction by one accepted byte request
	task automatic predict_byte(input logic [7:0] d, input logic first, input logic last,
	                            input logic v6);
		int unsigned len;
		flow_key_t   key;
		logic [7:0]  proto;
		logic [15:0] sp;
		logic [15:0] dp;
		if (first || byte_pos == 0) begin
			clear_flow();
			mode6 = v6;
		end
		if (byte_pos < MAX_BYTES) begin
			if (mode6) take_v6(byte_pos, d);
			else take_v4(byte_pos, d);
			byte_pos++;
		end
		if (last) begin
			len        = byte_pos;
			proto      = proto_found;
			sp         = '0;
			dp         = '0;
			key.status = ST_OK;
			if (!mode6) begin
				if (frag_more || len < 32'(ihl_words) * 4) key.status = ST_V4_BAD;
			end else if (walk == PH_FIXED || walk == PH_EXT) begin
				key.status = ST_V6_TRUNC;
			end else if (walk == PH_UNKNOWN) begin
				key.status = ST_V6_UNKNOWN;
			end else if (len < hdr_start + (proto == PROTO_TCP ? TCP_HDR_BYTES
			                                                   : SMALL_HDR_BYTES)) begin
				key.status = ST_V6_TRUNC;
			end
			if (proto == PROTO_TCP || proto == PROTO_UDP) begin
				sp = xport_word[31:16];
				dp = xport_word[15:0];
			end else if (proto == PROTO_ICMP || (mode6 && proto == PROTO_ICMPV6)) begin
				sp = {8'd0, xport_word[31:24]};
				dp = {8'd0, xport_word[23:16]};
			end
			if (key.status != ST_OK) begin
				proto = '0;
				sp    = '0;
				dp    = '0;
			end
			key.is_ipv4     = !mode6;
			key.src_hi      = mode6 ? src_addr[0] : 64'd0;
			key.src_lo      = mode6 ? src_addr[1] : {32'd0, src_addr[1][31:0]};
			key.dst_hi      = mode6 ? dst_addr[0] : 64'd0;
			key.dst_lo      = mode6 ? dst_addr[1] : {32'd0, dst_addr[1][31:0]};
			key.protocol    = proto;
			key.source_port = sp;
			key.dest_port   = dp;
			flow_keys_due.push_back(key);
			clear_flow();
		end
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
	                             input logic [63:0] got, inout bit bad);
		if (want !== got) begin
			if (mismatches < 10)
				$display("tb: key %0d %s mismatch: expected %h got %h",
				         keys_seen, name, want, got);
			bad = 1'b1;
		end
	endtask

	// watch both channels: compare results, then predict from the new byte
	always @(posedge clk or negedge arst_n) begin : watch
		flow_key_t got;
		flow_key_t want;
		bit        bad;
		if (!arst_n) begin
			clear_flow();
			flow_keys_due.delete();
			mismatches = 0;
			keys_seen  = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status      = status_t'(m_tdata[1:0]);
				got.src_hi      = m_tdata[65:2];
				got.src_lo      = m_tdata[129:66];
				got.dst_hi      = m_tdata[193:130];
				got.dst_lo      = m_tdata[257:194];
				got.protocol    = m_tdata[265:258];
				got.source_port = m_tdata[281:266];
				got.dest_port   = m_tdata[297:282];
				got.is_ipv4     = m_tuser[0];
				if (flow_keys_due.size() == 0) begin
					if (mismatches < 10)
						$display("tb: key %0d arrived with none predicted", keys_seen);
					mismatches++;
				end else begin
					want = flow_keys_due.pop_front();
					bad  = 1'b0;
					compare_field("status", want.status, got.status, bad);
					compare_field("is_ipv4", want.is_ipv4, got.is_ipv4, bad);
					compare_field("src_addr_hi", want.src_hi, got.src_hi, bad);
					compare_field("src_addr_lo", want.src_lo, got.src_lo, bad);
					compare_field("dst_addr_hi", want.dst_hi, got.dst_hi, bad);
					compare_field("dst_addr_lo", want.dst_lo, got.dst_lo, bad);
					compare_field("protocol", want.protocol, got.protocol, bad);
					compare_field("source_port", want.source_port, got.source_port, bad);
					compare_field("dest_port", want.dest_port, got.dest_port, bad);
					compare_field("zero fill", 64'd0, m_tdata[303:298], bad);
					if (bad) mismatches++;
				end
				keys_seen++;
			end
			if (s_tvalid && s_tready)
				predict_byte(s_tdata, s_tuser[0], s_tlast, s_tuser[1]);
			fail_count <= mismatches;
			pending    <= flow_keys_due.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// testbench top: feeds packet bytes to the flow key parser and reports the verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import iphfk_pkg::*;

	localparam int MAX_BYTES    = MAX_PACKET_BYTES_DEF;
	localparam int RANDOM_BYTES = 1950;
	localparam int QUIET_BYTES  = 250;
	localparam int HOLD_CYCLES  = 300;
	localparam int END_WAIT     = 20;
	localparam int CYCLE_LIMIT  = 1500000;

	logic         clk;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata  = '0;   // data_byte
	logic         s_axis_tlast  = 1'b0; // last_byte
	logic [1:0]   s_axis_tuser  = '0;   // first_byte, ipv6_mode
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b1;
	// status, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, protocol,
	// source_port, dest_port, zero fill
	logic [303:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;         // is_ipv4

	int           fail_count;
	int           pending;
	int           cycles;
	int           bytes_sent    = 0;
	int           src_idle_pct  = 20;
	int           sink_idle_pct = 20;
	bit           hold_req      = 1'b0;
	logic [7:0]   pkt [$];

	ip_header_flow_key_parser_unit #(
		.MAX_PACKET_BYTES(MAX_BYTES)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	flow_key_checker #(
		.MAX_BYTES(MAX_BYTES)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tlast    (s_axis_tlast),
		.s_tuser    (s_axis_tuser),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tuser    (m_axis_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run guard
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// result receiver: random stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// offer one byte request and wait for its handshake
	task automatic push_byte(input logic [7:0] d, input logic first, input logic last,
	                         input logic v6);
		if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tlast  <= last;
		s_axis_tuser  <= {v6, first};
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	// send the bytes in pkt; the mode bit only matters on the opening byte
	task automatic send_packet(input logic v6, input logic mark_first, input logic with_last);
		for (int i = 0; i < pkt.size(); i++)
			push_byte(pkt[i], i == 0 ? mark_first : 1'b0, with_last && i == pkt.size() - 1,
			          i == 0 ? v6 : 1'($urandom));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [7:0] any_proto();
		case ($urandom_range(0, 4))
			0: return PROTO_TCP;
			1: return PROTO_UDP;
			2: return PROTO_ICMP;
			3: return PROTO_ICMPV6;
			default: return 8'($urandom);
		endcase
	endfunction

	// ipv4 packet: header of at least 20 bytes, then tail bytes, cut to keep if not negative
	task automatic build_v4(input int ihl, input bit mf, input logic [7:0] proto,
	                        input int tail, input int keep);
		int n;
		n = (ihl * 4 > 20 ? ihl * 4 : 20) + tail;
		pkt.delete();
		repeat (n) pkt.push_back(8'($urandom));
		pkt[V4_OFF_IHL]   = {4'h4, 4'(ihl)};
		pkt[V4_OFF_FLAGS] = (pkt[V4_OFF_FLAGS] & 8'hdf) | {2'b00, mf, 5'b00000};
		pkt[V4_OFF_PROTO] = proto;
		while (keep >= 0 && pkt.size() > keep) void'(pkt.pop_back());
	endtask

	// ipv6 packet: fixed header, up to four extension headers, then tail bytes
	task automatic build_v6(input int n_ext, input int rot, input int len_max,
	                        input logic [7:0] final_nh, input int tail, input int keep);
		logic [7:0] kinds [5];
		logic [7:0] ext_codes [4];
		int         hlen;
		ext_codes = '{NH_HOP_BY_HOP, NH_ROUTING, NH_FRAGMENT, NH_DEST_OPTS};
		for (int i = 0; i < n_ext; i++)
			kinds[i] = ext_codes[rot < 0 ? $urandom_range(0, 3) : (i + rot) % 4];
		kinds[n_ext] = final_nh;
		pkt.delete();
		repeat (V6_FIXED_BYTES) pkt.push_back(8'($urandom));
		pkt[V6_OFF_NH] = kinds[0];
		for (int i = 0; i < n_ext; i++) begin
			hlen = $urandom_range(0, len_max);
			pkt.push_back(kinds[i + 1]);
			pkt.push_back(8'(hlen));
			repeat ((hlen + 1) * EXT_UNIT_BYTES - 2) pkt.push_back(8'($urandom));
		end
		repeat (tail) pkt.push_back(8'($urandom));
		while (keep >= 0 && pkt.size() > keep) void'(pkt.pop_back());
	endtask

	// stimulus and verdict
	initial begin
		int  pick;
		int  next_shift;
		int  n;
		bit  held;
		bit  long_ext;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed ipv4 cases
		build_v4(5, 0, PROTO_TCP, 20, -1);      send_packet(0, 1, 1);
		build_v4(5, 0, PROTO_UDP, 8, -1);       send_packet(0, 1, 1);
		build_v4(5, 0, PROTO_ICMP, 8, -1);      send_packet(0, 1, 1);
		build_v4(6, 1, PROTO_TCP, 20, -1);      send_packet(0, 1, 1);
		build_v4(15, 0, PROTO_UDP, 0, 40);      send_packet(0, 1, 1);
		build_v4(2, 0, PROTO_TCP, 0, -1);       send_packet(0, 1, 1);
		build_v4(0, 0, PROTO_UDP, 0, -1);       send_packet(0, 1, 1);
		build_v4(5, 0, PROTO_ICMPV6, 8, -1);    send_packet(0, 1, 1);
		build_v4(5, 0, 8'd200, 8, -1);          send_packet(0, 1, 1);
		build_v4(5, 0, PROTO_TCP, 2, -1);       send_packet(0, 1, 1);
		build_v4(5, 0, PROTO_TCP, 20, 12);      send_packet(0, 0, 1);
		// directed ipv6 cases
		build_v6(4, 0, 2, PROTO_TCP, 20, -1);   send_packet(1, 1, 1);
		build_v6(0, 0, 0, PROTO_UDP, 8, -1);    send_packet(1, 1, 1);
		build_v6(1, 1, 0, PROTO_ICMPV6, 8, -1); send_packet(1, 1, 1);
		build_v6(0, 0, 0, PROTO_ICMP, 8, -1);   send_packet(1, 1, 1);
		build_v6(0, 0, 0, PROTO_TCP, 20, 30);   send_packet(1, 1, 1);
		build_v6(2, 2, 1, PROTO_UDP, 8, 50);    send_packet(1, 1, 1);
		build_v6(0, 0, 0, PROTO_TCP, 10, -1);   send_packet(1, 1, 1);
		build_v6(1, 3, 0, 8'd59, 8, -1);        send_packet(1, 1, 1);
		// single byte packets, then all-zero and all-ones packets in both modes
		pkt = '{8'h45};
		send_packet(0, 1, 1);
		send_packet(1, 1, 1);
		for (int k = 0; k < 4; k++) begin
			pkt.delete();
			repeat (64) pkt.push_back(k[0] ? 8'hff : 8'h00);
			send_packet(k[1], 1, 1);
		end
		// packet dropped by a new first byte
		build_v4(5, 0, PROTO_TCP, 20, -1);      send_packet(0, 1, 0);
		build_v6(0, 0, 0, PROTO_UDP, 8, -1);    send_packet(1, 1, 1);

		// random packets
		next_shift = 0;
		held       = 1'b0;
		while (bytes_sent < RANDOM_BYTES) begin
			if (bytes_sent >= RANDOM_BYTES - QUIET_BYTES) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end else if (bytes_sent >= next_shift) begin
				src_idle_pct  = $urandom_range(0, 2) * 20;
				sink_idle_pct = $urandom_range(0, 2) * 20;
				next_shift    = bytes_sent + 200;
			end
			// receiver holds off while short packets keep coming, then drain
			if (!held && bytes_sent > 800) begin
				held         = 1'b1;
				src_idle_pct = 0;
				hold_req     = 1'b1;
				repeat (8) begin
					build_v4(5, 0, PROTO_UDP, 8, -1);
					send_packet(0, 1, 1);
				end
				wait_drained();
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				build_v4($urandom_range(0, 99) < 85 ? $urandom_range(5, 15) : $urandom_range(0, 4),
				         $urandom_range(0, 9) == 0, any_proto(), $urandom_range(0, 24),
				         $urandom_range(0, 9) == 0 ? $urandom_range(1, 30) : -1);
				send_packet(0, $urandom_range(0, 9) != 0, 1);
			end else if (pick < 85) begin
				// rare long extension headers are always cut short
				long_ext = $urandom_range(0, 49) == 0;
				build_v6($urandom_range(0, 4), -1, long_ext ? 255 : 2,
				         $urandom_range(0, 9) == 0 ? 8'($urandom) : any_proto(),
				         $urandom_range(0, 28),
				         (long_ext || $urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : -1);
				send_packet(1, $urandom_range(0, 9) != 0, 1);
			end else if (pick < 95) begin
				// noise with stray first flags
				n = $urandom_range(1, 60);
				for (int i = 0; i < n; i++)
					push_byte(8'($urandom), $urandom_range(0, 7) == 0, i == n - 1,
					          1'($urandom));
			end else begin
				// packet left open, merged into or dropped by the next one
				if ($urandom_range(0, 1)) begin
					build_v4(5, 0, any_proto(), $urandom_range(0, 20), -1);
					send_packet(0, 1, 0);
				end else begin
					build_v6($urandom_range(0, 2), -1, 2, any_proto(), $urandom_range(0, 20), -1);
					send_packet(1, 1, 0);
				end
			end
		end

		wait_drained();
		repeat (END_WAIT) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
